>>> hw/rtl/trah_pkg.sv
// Shared types and constants for the texture rotate-add hash block.
package trah_pkg;

   localparam int WORD_BITS  = 32;
   localparam int POS_BITS   = 12;
   localparam int ROW_BITS   = 10;
   localparam int INDEX_BITS = 8;
   localparam int MODE_BITS  = 2;
   localparam int ROT_BITS   = 4;
   localparam int NIBBLE_BITS = 4;
   localparam int BYTE_BITS   = 8;
   localparam int NIBBLES_PER_WORD = WORD_BITS / NIBBLE_BITS;
   localparam int BYTES_PER_WORD   = WORD_BITS / BYTE_BITS;

   localparam int REQ_PAYLOAD_BITS = WORD_BITS + POS_BITS + ROW_BITS;
   localparam int REQ_TDATA_BITS   = ((REQ_PAYLOAD_BITS + 7) / 8) * 8;
   localparam int RSP_PAYLOAD_BITS = WORD_BITS + INDEX_BITS;
   localparam int RSP_TDATA_BITS   = ((RSP_PAYLOAD_BITS + 7) / 8) * 8;

   localparam logic [MODE_BITS-1:0] MODE_PLAIN  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_NIBBLE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BYTE   = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [WORD_BITS-1:0] texel_word;
      logic [POS_BITS-1:0]  byte_pos;
      logic [ROW_BITS-1:0]  row_number;
      logic                 end_of_row;
      logic                 end_of_image;
   } trah_item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  hash;
      logic [INDEX_BITS-1:0] max_index;
   } trah_result_type;

endpackage

>>> hw/rtl/trah_max_unit.sv
// Largest colour index of one word, merged with the running maximum.
module trah_max_unit (
   input  logic [trah_pkg::MODE_BITS-1:0]  mode,
   input  logic [trah_pkg::WORD_BITS-1:0]  word,
   input  logic [trah_pkg::INDEX_BITS-1:0] cur_max,
   output logic [trah_pkg::INDEX_BITS-1:0] new_max
);
   import trah_pkg::*;

   always_comb begin
      new_max = cur_max;
      case (mode)
         MODE_NIBBLE: begin
            for (int i = 0; i < NIBBLES_PER_WORD; i++) begin
               if ({4'b0, word[i*NIBBLE_BITS +: NIBBLE_BITS]} > new_max) begin
                  new_max = {4'b0, word[i*NIBBLE_BITS +: NIBBLE_BITS]};
               end
            end
         end
         MODE_BYTE: begin
            for (int i = 0; i < BYTES_PER_WORD; i++) begin
               if (word[i*BYTE_BITS +: BYTE_BITS] > new_max) begin
                  new_max = word[i*BYTE_BITS +: BYTE_BITS];
               end
            end
         end
         default: begin
            new_max = cur_max;
         end
      endcase
   end

endmodule

>>> hw/rtl/trah_hash_unit.sv
// Running hash and index-maximum state, updated once per accepted word.
module trah_hash_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  trah_pkg::trah_item_type        item,
   input  logic [trah_pkg::MODE_BITS-1:0] mode,
   output trah_pkg::trah_result_type      result
);
   import trah_pkg::*;

   logic [WORD_BITS-1:0]  running_hash_ff;
   logic [WORD_BITS-1:0]  running_hash_in;
   logic [INDEX_BITS-1:0] largest_index_ff;
   logic [INDEX_BITS-1:0] largest_index_in;
   logic [WORD_BITS-1:0]  texel_mix;
   logic [WORD_BITS-1:0]  rotated;
   logic [WORD_BITS-1:0]  row_term;
   logic [WORD_BITS-1:0]  hash_next;
   logic [INDEX_BITS-1:0] max_next;
   logic                  tracking;

   trah_max_unit u_max (
      .mode    (mode),
      .word    (item.texel_word),
      .cur_max (largest_index_ff),
      .new_max (max_next)
   );

   assign texel_mix = {{(WORD_BITS-POS_BITS){1'b0}}, item.byte_pos} ^ item.texel_word;
   assign rotated   = {running_hash_ff[WORD_BITS-ROT_BITS-1:0],
                       running_hash_ff[WORD_BITS-1 -: ROT_BITS]};
   assign row_term  = item.end_of_row ?
                      ({{(WORD_BITS-ROW_BITS){1'b0}}, item.row_number} ^ texel_mix) : '0;
   assign hash_next = texel_mix + rotated + row_term;
   assign tracking  = (mode == MODE_NIBBLE) || (mode == MODE_BYTE);

   assign result.hash      = hash_next;
   assign result.max_index = tracking ? max_next : '0;

   always_comb begin
      running_hash_in  = running_hash_ff;
      largest_index_in = largest_index_ff;
      if (step) begin
         if (item.end_of_image) begin
            running_hash_in  = '0;
            largest_index_in = '0;
         end else begin
            running_hash_in  = hash_next;
            largest_index_in = max_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff  <= '0;
         largest_index_ff <= '0;
      end else begin
         running_hash_ff  <= running_hash_in;
         largest_index_ff <= largest_index_in;
      end
   end

   a_clear_after_image: assert property (@(posedge clock) disable iff (reset)
      step && item.end_of_image |=> (running_hash_ff == '0) && (largest_index_ff == '0))
      else $error("hash state not cleared after image end");

   a_max_held_plain: assert property (@(posedge clock) disable iff (reset)
      step && !item.end_of_image && !tracking |=> $stable(largest_index_ff))
      else $error("index maximum moved outside tracking mode");

   a_hash_advances: assert property (@(posedge clock) disable iff (reset)
      step && !item.end_of_image |=> running_hash_ff == $past(hash_next))
      else $error("running hash did not take the new value");

endmodule

>>> hw/rtl/texture_rotate_add_hash.sv
// Texture rotate-add hash: one word per unstalled cycle in, one hash per image out.
// The block takes one texel word transaction every clock cycle unless stalled and
// delivers the finished hash and largest colour index in the cycle after the
// transaction carrying end_of_image; other words give no result. The figure of one
// word per cycle is set by the running-hash feedback: XOR, rotate by four and a
// three-input 32-bit add feed the hash register. The result sits in an output
// register; a new word is taken while it is empty or being drained in the same
// cycle. The user must write index_mode through csr_we/csr_wdata only while no image
// is in flight (not enforced by the block); writes leave the hash state untouched.
module texture_rotate_add_hash (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [trah_pkg::MODE_BITS-1:0]       csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // texel_word [31:0], byte_pos [43:32], row_number [53:44], zero [55:54]
   input  logic [trah_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   input  logic                                 req_tlast,
   // end_of_image [0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hash [31:0], max_index [39:32]
   output logic [trah_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);
   import trah_pkg::*;

   logic [MODE_BITS-1:0]      index_mode_ff;
   logic                      rsp_tvalid_ff;
   logic                      rsp_tvalid_in;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata_in;
   logic                      req_accept;
   logic                      emit;
   trah_item_type             item;
   trah_result_type           result;

   assign item.texel_word   = req_tdata[WORD_BITS-1:0];
   assign item.byte_pos     = req_tdata[WORD_BITS +: POS_BITS];
   assign item.row_number   = req_tdata[WORD_BITS+POS_BITS +: ROW_BITS];
   assign item.end_of_row   = req_tlast;
   assign item.end_of_image = req_tuser;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign emit       = req_accept && req_tuser;

   trah_hash_unit u_hash (
      .clock  (clock),
      .reset  (reset),
      .step   (req_accept),
      .item   (item),
      .mode   (index_mode_ff),
      .result (result)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{(RSP_TDATA_BITS-RSP_PAYLOAD_BITS){1'b0}},
                          result.max_index, result.hash};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_mode_ff <= MODE_PLAIN;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            index_mode_ff <= csr_wdata;
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_result_follows_image: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid)
      else $error("no result after image end");

   a_plain_max_zero: assert property (@(posedge clock) disable iff (reset)
      emit && (index_mode_ff == MODE_PLAIN || index_mode_ff == MODE_UNUSED)
      |=> rsp_tdata[WORD_BITS +: INDEX_BITS] == '0)
      else $error("nonzero max index in plain mode");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !emit |=> !rsp_tvalid)
      else $error("result without image end");

endmodule

>>> test/testbench.sv
// Testbench for the texture rotate-add hash block: directed and random texel streams.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import trah_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int PRINT_CAP = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [MODE_BITS-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;

   logic [MODE_BITS-1:0]  model_mode = MODE_PLAIN;
   logic [WORD_BITS-1:0]  model_hash = '0;
   logic [WORD_BITS-1:0]  model_texel_mix = '0;
   logic [INDEX_BITS-1:0] model_max_index = '0;
   trah_result_type       pending_hashes[$];

   texture_rotate_add_hash dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic void absorb_word(input logic [WORD_BITS-1:0] word,
                                       input logic [POS_BITS-1:0] pos,
                                       input logic [ROW_BITS-1:0] row,
                                       input logic eor, input logic eoi);
      logic [WORD_BITS-1:0] wh;
      logic [INDEX_BITS-1:0] unit;
      trah_result_type res;
      if (model_mode == MODE_NIBBLE) begin
         for (int i = 0; i < NIBBLES_PER_WORD; i++) begin
            unit = {4'b0, word[i*NIBBLE_BITS +: NIBBLE_BITS]};
            if (unit > model_max_index) model_max_index = unit;
         end
      end else if (model_mode == MODE_BYTE) begin
         for (int i = 0; i < BYTES_PER_WORD; i++) begin
            unit = word[i*BYTE_BITS +: BYTE_BITS];
            if (unit > model_max_index) model_max_index = unit;
         end
      end
      wh = WORD_BITS'(pos) ^ word;
      model_texel_mix = wh;
      model_hash = wh + ((model_hash << ROT_BITS) | (model_hash >> (WORD_BITS - ROT_BITS)));
      if (eor) model_hash = model_hash + (WORD_BITS'(row) ^ model_texel_mix);
      if (eoi) begin
         res.hash = model_hash;
         res.max_index = (model_mode == MODE_NIBBLE || model_mode == MODE_BYTE) ?
                         model_max_index : '0;
         pending_hashes.push_back(res);
         model_hash = '0;
         model_texel_mix = '0;
         model_max_index = '0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                  input logic [WORD_BITS-1:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      trah_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hashes.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[WORD_BITS-1:0], '0);
         end else begin
            want = pending_hashes.pop_front();
            if (rsp_tdata[WORD_BITS-1:0] !== want.hash)
               report_mismatch("hash", rsp_tdata[WORD_BITS-1:0], want.hash);
            if (rsp_tdata[WORD_BITS +: INDEX_BITS] !== want.max_index)
               report_mismatch("max_index", rsp_tdata[WORD_BITS +: INDEX_BITS],
                               want.max_index);
         end
      end
   end

   task automatic send_texel(input logic [WORD_BITS-1:0] word, input logic [POS_BITS-1:0] pos,
                             input logic [ROW_BITS-1:0] row, input logic eor,
                             input logic eoi);
      logic [REQ_TDATA_BITS-1:0] packed_data;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      packed_data = '0;
      packed_data[REQ_PAYLOAD_BITS-1:0] = {row, pos, word};
      req_tvalid <= 1'b1;
      req_tdata <= packed_data;
      req_tlast <= eor;
      req_tuser <= eoi;
      do @(posedge clock); while (!req_tready);
      absorb_word(word, pos, row, eor, eoi);
      @(negedge clock);
   endtask

   task automatic wait_for_hashes();
      req_tvalid <= 1'b0;
      while (pending_hashes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input logic [MODE_BITS-1:0] mode);
      wait_for_hashes();
      csr_we <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we <= 1'b0;
      model_mode = mode;
      @(negedge clock);
   endtask

   task automatic test_field_extremes();
      set_mode(MODE_BYTE);
      send_texel(32'h0000_0000, 12'd0, 10'd0, 1'b1, 1'b1);
      send_texel(32'hFFFF_FFFF, 12'd4092, 10'd1023, 1'b0, 1'b0);
      send_texel(32'h8000_0000, 12'd0, 10'd1023, 1'b1, 1'b0);
      send_texel(32'h0000_000F, 12'd2048, 10'd512, 1'b1, 1'b1);
      set_mode(MODE_NIBBLE);
      send_texel(32'h1234_5678, 12'd4, 10'd1, 1'b0, 1'b0);
      send_texel(32'h7000_0003, 12'd0, 10'd1, 1'b1, 1'b0);
      send_texel(32'h0A00_0000, 12'd0, 10'd0, 1'b1, 1'b1);
   endtask

   task automatic test_unused_mode();
      set_mode(MODE_UNUSED);
      send_texel(32'hFEDC_BA98, 12'd4, 10'd0, 1'b0, 1'b0);
      send_texel(32'hFFFF_FFFF, 12'd0, 10'd0, 1'b1, 1'b1);
   endtask

   task automatic test_missing_row_end();
      set_mode(MODE_PLAIN);
      send_texel(32'hDEAD_BEEF, 12'd8, 10'd3, 1'b0, 1'b0);
      send_texel(32'h0123_4567, 12'd4, 10'd3, 1'b0, 1'b1);
   endtask

   task automatic test_mode_switch_mid_image();
      set_mode(MODE_NIBBLE);
      send_texel(32'h0000_00C0, 12'd12, 10'd1, 1'b0, 1'b0);
      send_texel(32'h0000_0001, 12'd8, 10'd1, 1'b0, 1'b0);
      set_mode(MODE_BYTE);
      send_texel(32'h0000_00E1, 12'd4, 10'd1, 1'b0, 1'b0);
      send_texel(32'h0000_0002, 12'd0, 10'd1, 1'b1, 1'b0);
      set_mode(MODE_NIBBLE);
      send_texel(32'h0000_0003, 12'd0, 10'd0, 1'b1, 1'b1);
      set_mode(MODE_BYTE);
      send_texel(32'h0000_7F00, 12'd4, 10'd0, 1'b0, 1'b0);
      set_mode(MODE_PLAIN);
      send_texel(32'h0000_0011, 12'd0, 10'd0, 1'b1, 1'b1);
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                     input logic [MODE_BITS-1:0] mode, input int count);
      int sent;
      int height;
      int width;
      int limit;
      int n;
      logic [WORD_BITS-1:0] mask;
      set_mode(mode);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(4) != 0) begin
            if ($urandom_range(9) == 0) begin
               height = $urandom_range(1, 32);
               width = $urandom_range(1, 64);
            end else begin
               height = $urandom_range(1, 4);
               width = $urandom_range(1, 8);
            end
            case ($urandom_range(3))
               0: mask = '1;
               1: mask = $urandom;
               2: mask = 32'h7F7F_7F7F;
               default: mask = 32'h0F0F_0F0F >> $urandom_range(4);
            endcase
            limit = height * width;
            if ($urandom_range(7) == 0) limit = $urandom_range(1, limit);
            n = 0;
            for (int r = height - 1; r >= 0; r--) begin
               for (int w = width - 1; w >= 0; w--) begin
                  if (n < limit && sent < count) begin
                     send_texel($urandom & mask, POS_BITS'(w * 4), ROW_BITS'(r), w == 0,
                                r == 0 && w == 0);
                     n++;
                     sent++;
                  end
               end
            end
            if ($urandom_range(39) == 0) wait_for_hashes();
         end else begin
            send_texel($urandom, POS_BITS'($urandom), ROW_BITS'($urandom),
                       1'($urandom_range(1)), $urandom_range(3) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_field_extremes();
      test_unused_mode();
      test_missing_row_end();
      test_mode_switch_mid_image();
      test_random_stream(0, 0, MODE_NIBBLE, 500);
      test_random_stream(63, 0, MODE_BYTE, 500);
      test_random_stream(0, 63, MODE_PLAIN, 500);
      test_random_stream(15, 15, MODE_UNUSED, 250);
      test_random_stream(15, 15, MODE_BYTE, 250);
      wait_for_hashes();
      repeat (8) @(negedge clock);
      if (pending_hashes.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/trah_pkg.sv
hw/rtl/trah_max_unit.sv
hw/rtl/trah_hash_unit.sv
hw/rtl/texture_rotate_add_hash.sv
test/testbench.sv
